>>> src/ffba_pkg.sv
// ffba_pkg.sv: shared types and codes of the first-fit block allocator
`timescale 1ns / 1ps

package ffba_pkg;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_DEFRAG = 2'd2;

  localparam logic [1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [1:0] STAT_NULL      = 2'd1;
  localparam logic [1:0] STAT_ILLEGAL   = 2'd2;
  localparam logic [1:0] STAT_DONE      = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] argument;
  } ffba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_id;
  } ffba_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_ZERO
  } ffba_state_t;

endpackage

>>> src/ffba_ram.sv
// ffba_ram.sv: generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ffba_seq.sv
// ffba_seq.sv: command sequencer that scans and rewrites the cell ram
`timescale 1ns / 1ps

module ffba_seq
  import ffba_pkg::*;
#(
  parameter int CELL_COUNT = 128,
  parameter int ID_BITS = 16,
  localparam int CB = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1,
  localparam int CNT_W = $clog2(CELL_COUNT + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ffba_req_t          request,
  input  logic [CNT_W-1:0]   cell_count,
  output logic               busy,
  output logic               done,
  output ffba_res_t          result,
  output logic               mem_we,
  output logic [CB-1:0]      mem_waddr,
  output logic [ID_BITS-1:0] mem_wdata,
  output logic [CB-1:0]      mem_raddr,
  input  logic [ID_BITS-1:0] mem_rdata
);

  localparam logic [ID_BITS-1:0] ID_MASK = '1;
  localparam logic [CB-1:0] LAST_CELL = CB'(CELL_COUNT - 1);

  ffba_state_t state, state_next;

  logic [1:0]         cmd;
  logic [31:0]        arg;
  logic [CNT_W-1:0]   len;
  logic [CNT_W-1:0]   rd_idx;
  logic               pend;
  logic [CB-1:0]      pend_idx;
  logic [CNT_W-1:0]   run;
  logic [CB-1:0]      run_start;
  logic               hit;
  logic [CNT_W-1:0]   wr_idx;
  logic [CB-1:0]      fill_ptr;
  logic [CB-1:0]      fill_end;
  logic [CB-1:0]      clr_idx;
  logic [ID_BITS-1:0] last_id;
  logic [31:0]        id_wide;

  logic req_pos, alloc_ok, scan_issue, scan_end, cell_free, alloc_hit, erase_hit;
  logic zero_last;

  assign req_pos  = !request.argument[31] && (request.argument != 32'sd0);
  assign alloc_ok = req_pos && (32'(cell_count) >= $unsigned(request.argument))
                    && (last_id != ID_MASK);

  assign scan_issue = (state == S_SCAN) && (rd_idx < cell_count);
  assign scan_end   = (state == S_SCAN) && !pend && !scan_issue;
  assign cell_free  = (mem_rdata == '0);
  // run of free cells reaches the requested length on this cell
  assign alloc_hit  = (state == S_SCAN) && pend && (cmd == CMD_ALLOC) && cell_free
                      && (CNT_W'(run + 1'b1) == len);
  assign erase_hit  = pend && (cmd == CMD_ERASE) && (32'(mem_rdata) == arg);
  assign zero_last  = (CNT_W'(wr_idx + 1'b1) >= cell_count);
  assign id_wide    = 32'(last_id);
  assign busy       = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_CELL) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (request.command)
            CMD_ALLOC:  if (alloc_ok) state_next = S_SCAN;
            CMD_ERASE:  if (req_pos) state_next = S_SCAN;
            CMD_DEFRAG: state_next = S_SCAN;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (alloc_hit) begin
          state_next = S_FILL;
        end else if (scan_end) begin
          if (cmd == CMD_DEFRAG && wr_idx < cell_count) state_next = S_ZERO;
          else state_next = S_IDLE;
        end
      end
      S_FILL: begin
        if (fill_ptr == fill_end) state_next = S_IDLE;
      end
      S_ZERO: begin
        if (zero_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram port controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_idx;
    mem_wdata = '0;
    mem_raddr = rd_idx[CB-1:0];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_SCAN: begin
        if (erase_hit) begin
          mem_we = 1'b1;
        end else if (pend && cmd == CMD_DEFRAG && !cell_free) begin
          // move the used cell down to the packing pointer
          mem_we    = 1'b1;
          mem_waddr = wr_idx[CB-1:0];
          mem_wdata = mem_rdata;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_ptr;
        mem_wdata = last_id;
      end
      S_ZERO: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx[CB-1:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      last_id <= '0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= scan_issue;
      done  <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            cmd    <= request.command;
            arg    <= $unsigned(request.argument);
            len    <= request.argument[CNT_W-1:0];
            rd_idx <= '0;
            run    <= '0;
            hit    <= 1'b0;
            wr_idx <= '0;
            result.block_id <= '0;
            case (request.command)
              CMD_ALLOC: begin
                if (!alloc_ok) begin
                  done          <= 1'b1;
                  result.status <= STAT_NULL;
                end
              end
              CMD_ERASE: begin
                if (!req_pos) begin
                  done          <= 1'b1;
                  result.status <= STAT_ILLEGAL;
                end
              end
              CMD_DEFRAG: done <= 1'b0;
              default: begin
                done          <= 1'b1;
                result.status <= STAT_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            rd_idx   <= rd_idx + 1'b1;
            pend_idx <= rd_idx[CB-1:0];
          end
          if (pend) begin
            if (cell_free) begin
              run <= run + 1'b1;
              if (run == '0) run_start <= pend_idx;
            end else begin
              run <= '0;
            end
            if (erase_hit) hit <= 1'b1;
            if (cmd == CMD_DEFRAG && !cell_free) wr_idx <= wr_idx + 1'b1;
          end
          if (alloc_hit) begin
            fill_ptr <= (run == '0) ? pend_idx : run_start;
            fill_end <= pend_idx;
            last_id  <= last_id + 1'b1;
          end else if (scan_end) begin
            case (cmd)
              CMD_ALLOC: begin
                done          <= 1'b1;
                result.status <= STAT_NULL;
              end
              CMD_ERASE: begin
                done          <= 1'b1;
                result.status <= hit ? STAT_DONE : STAT_ILLEGAL;
              end
              default: begin
                if (wr_idx >= cell_count) begin
                  done          <= 1'b1;
                  result.status <= STAT_DONE;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          fill_ptr <= fill_ptr + 1'b1;
          if (fill_ptr == fill_end) begin
            done            <= 1'b1;
            result.status   <= STAT_ALLOCATED;
            result.block_id <= id_wide[15:0];
          end
        end
        S_ZERO: begin
          wr_idx <= wr_idx + 1'b1;
          if (zero_last) begin
            done          <= 1'b1;
            result.status <= STAT_DONE;
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("cell ram written while idle");

  a_id_only_on_alloc: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.block_id == '0 || result.status == STAT_ALLOCATED))
    else $error("nonzero block id on a failed transaction");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (fill_ptr <= fill_end && last_id != '0))
    else $error("fill pointer past end of run");

  a_scan_write_needs_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |-> pend)
    else $error("scan write without read data");

  a_fill_follows_hit: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_FILL) |-> $past(alloc_hit))
    else $error("fill entered without a free run");

endmodule

>>> src/first_fit_block_allocator_core.sv
// first_fit_block_allocator_core.sv: top level of the first-fit block allocator
`timescale 1ns / 1ps
//
//  channel   signals                     transaction
//  command   start, busy, request        start && !busy
//  result    done, result                done (one cycle, no back-pressure)
//  config    cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
//
//  erase and a failed allocate scan the m = min(memory_size, CELL_COUNT) cells in use at
//  one cell a cycle; a successful allocate stops at the end of its run and stamps one cell
//  a cycle; defragment packs the used cells down and clears the free cells left at the top.
//  rejected arguments and unused commands answer without a scan.
//  after reset a clearing pass zeroes all CELL_COUNT cells of the cell ram, busy stays high.
//  the cell ram port (one read, one write per cycle) sets the rate; done is never stalled.

module first_fit_block_allocator_core
  import ffba_pkg::*;
#(
  parameter int CELL_COUNT = 128,
  parameter int ID_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ffba_req_t request,
  output logic      busy,
  output logic      done,
  output ffba_res_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CB = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W = $clog2(CELL_COUNT + 1);
  localparam int SZ_W = (CNT_W > 8) ? CNT_W : 8;

  logic [7:0]         memory_size;
  logic [SZ_W-1:0]    size_wide;
  logic [CNT_W-1:0]   cell_count;
  logic               mem_we;
  logic [CB-1:0]      mem_waddr;
  logic [CB-1:0]      mem_raddr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [ID_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      memory_size <= cfg_data;
    end
  end

  // register value saturates at the built cell count
  assign size_wide  = SZ_W'(memory_size);
  assign cell_count = (size_wide > SZ_W'(CELL_COUNT)) ? CNT_W'(CELL_COUNT)
                                                      : CNT_W'(size_wide);

  ffba_seq #(
    .CELL_COUNT(CELL_COUNT),
    .ID_BITS(ID_BITS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .cell_count(cell_count),
    .busy(busy),
    .done(done),
    .result(result),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ffba_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
